@@ sv/assert_macros.svh @@
// Assertion macros for the port-level checker.
// Depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define AST_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ sv/pgu_pkg.sv @@
// Package for the Potts graph update block: codes, widths and sigmoid table.
// Depends on nothing.
`default_nettype none
package pgu_pkg;
	localparam int MAX_NODES = 4096;
	localparam int MAX_ADJ = 65536;
	localparam int MAX_DEGREE = 256;
	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int ADJ_W = $clog2(MAX_ADJ);
	localparam int DEG_W = $clog2(MAX_DEGREE) + 1;
	localparam int CNT_W = NODE_W + 1;
	localparam int ONE_Q14 = 16384;
	localparam int DU_W = 28;

	typedef enum logic [1:0] {
		CMD_LOAD_NODE = 2'd0,
		CMD_LOAD_ADJ = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_COUNT = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_NODE_COUNT = 2'd0,
		REG_EPSILON = 2'd1,
		REG_INV_TEMP = 2'd2,
		REG_ZEALOT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] strategy;
		logic locked;
		logic [ADJ_W-1:0] adj_start;
		logic [DEG_W-1:0] degree;
	} node_rec_t;

	// Restoring division, evaluated only while the table is built.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], num[b]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [16:0] sig_pos(input int k);
		logic [63:0] p;
		logic [63:0] d;
		logic [16:0] s;
		p = 64'd1 << 32;
		s = 17'd32768;
		for (int j = 0; j <= 128; j++) begin
			d = (64'd1 << 32) + p;
			if (j == k) s = 17'(udiv64((64'd1 << 48) + (d >> 1), d));
			p = (p * 64'd4034748382 + (64'd1 << 31)) >> 32;
		end
		if (k == 0) s = 17'd32768;
		return s;
	endfunction

	typedef logic [16:0] sig_arr_t [0:128];
	function automatic sig_arr_t build_sig();
		sig_arr_t t;
		for (int k = 0; k <= 128; k++) t[k] = sig_pos(k);
		return t;
	endfunction
	localparam sig_arr_t SIG_TABLE = build_sig();
endpackage
`default_nettype wire

@@ sv/pgu_sigmoid.sv @@
// Sigmoid lookup stage: maps the scaled energy change to an acceptance level.
// Depends on pgu_pkg.
`default_nettype none
module pgu_sigmoid (
	input wire logic clk,
	input wire logic signed [pgu_pkg::DU_W-1:0] du,
	input wire logic [15:0] inv_temp,
	output logic [16:0] level
);
	import pgu_pkg::*;
	logic signed [DU_W+17-1:0] x_s1;
	logic signed [DU_W+17-1:0] y;
	logic signed [DU_W-1:0] idx;
	logic [7:0] mag;
	always_ff @(posedge clk) begin
		x_s1 <= du * $signed({1'b0, inv_temp});
	end
	always_comb begin
		y = x_s1 + 45'sd131072;
		idx = DU_W'(y >>> 18);
		if (idx > 28'sd128) begin
			level = SIG_TABLE[128];
		end else if (idx < -28'sd128) begin
			level = 17'd65536 - SIG_TABLE[128];
		end else if (idx >= 0) begin
			mag = idx[7:0];
			level = (idx == 28'sd128) ? SIG_TABLE[128] : SIG_TABLE[mag];
		end else begin
			mag = 8'(-idx);
			level = (idx == -28'sd128) ? 17'd65536 - SIG_TABLE[128]
				: 17'd65536 - SIG_TABLE[mag];
		end
		if (!(idx >= 0) || idx > 28'sd128) mag = 8'd0;
		else mag = idx[7:0];
	end
endmodule
`default_nettype wire

@@ sv/potts_glauber_graph_update.sv @@
// Top level of the Potts Glauber update block: node and adjacency stores,
// sequencer and energy accumulator. Depends on pgu_pkg, pgu_sigmoid.
//
// channel | signals                     | direction
// in      | in_valid/in_ready + fields  | into block
// out     | out_valid/out_ready + fields| out of block
// cfg     | cfg_we, cfg_idx, cfg_data   | into block
//
// A load writes its store in ST_NODE, then raises its result in ST_OUT. An update reads
// the node record and walks its neighbours (degree capped at 256), each with an adjacency
// read, then the neighbour's strategy read through the single node port; a locked
// or isolated node or a null step skips the walk. A count scans min(node_count, 4096)
// nodes through one node read port. Reset clears control state only; stores are
// undefined until written. While an item is at work or its result waits, in_ready is low.
`default_nettype none
module potts_glauber_graph_update (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] cmd,
	input wire logic [11:0] node,
	input wire logic [1:0] strategy,
	input wire logic zealot_flag,
	input wire logic [15:0] adj_start,
	input wire logic [8:0] degree,
	input wire logic [15:0] adj_addr,
	input wire logic [11:0] neighbour,
	input wire logic [1:0] prop_step,
	input wire logic [15:0] uniform,
	output logic out_valid,
	input wire logic out_ready,
	output logic accepted,
	output logic [1:0] new_strategy,
	output logic [12:0] count_rock,
	output logic [12:0] count_paper,
	output logic [12:0] count_scissors,
	output logic [12:0] free_converted,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_idx,
	input wire logic [15:0] cfg_data
);
	import pgu_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_NODE = 9'b000000010,
		ST_WALK = 9'b000000100,
		ST_NBR = 9'b000001000,
		ST_ADD = 9'b000010000,
		ST_MUL = 9'b000100000,
		ST_DEC = 9'b001000000,
		ST_CNT = 9'b010000000,
		ST_OUT = 9'b100000000
	} state_t;
	state_t state_q;

	logic [12:0] node_count_q;
	logic [14:0] epsilon_q;
	logic [15:0] inv_temp_q;
	logic [1:0] zealot_q;

	node_rec_t node_mem [0:MAX_NODES-1];
	logic [NODE_W-1:0] adj_mem [0:MAX_ADJ-1];

	logic [NODE_W-1:0] node_q;
	logic [1:0] step_q;
	logic [15:0] uni_q;
	logic [1:0] cmd_q;
	node_rec_t rec_q;
	logic [NODE_W-1:0] nbr_q;
	logic [DEG_W-1:0] k_q;
	logic [DEG_W-1:0] deg_q;
	logic [1:0] cur_q;
	logic [1:0] prop_q;
	logic signed [DU_W-1:0] du_q;
	logic [CNT_W-1:0] scan_q;
	logic [CNT_W-1:0] lim_q;
	logic [12:0] c0_q, c1_q, c2_q, cv_q;
	logic [16:0] level;
	logic mul_wait_q;
	logic wr_node_en;
	logic [NODE_W-1:0] node_addr;
	node_rec_t node_wdata;
	node_rec_t node_rd_q;
	logic [NODE_W-1:0] adj_rd_q;
	logic [ADJ_W-1:0] adj_raddr;

	function automatic logic signed [16:0] payoff(input logic [1:0] a, input logic [1:0] b,
		input logic [14:0] eps);
		logic [1:0] d;
		d = (b == a) ? 2'd0 : ((b == a + 2'd1) || (a == 2'd2 && b == 2'd0)) ? 2'd1 : 2'd2;
		case (d)
			2'd0: payoff = 17'sd16384;
			2'd1: payoff = -$signed({2'b00, eps});
			default: payoff = $signed({2'b00, eps});
		endcase
	endfunction

	assign in_ready = (state_q == ST_IDLE) && !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 13'd1;
			epsilon_q <= 15'd8192;
			inv_temp_q <= 16'd394;
			zealot_q <= 2'd0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_NODE_COUNT: node_count_q <= cfg_data[12:0];
				REG_EPSILON: epsilon_q <= cfg_data[14:0];
				REG_INV_TEMP: inv_temp_q <= cfg_data;
				REG_ZEALOT: zealot_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		wr_node_en = 1'b0;
		node_wdata = rec_q;
		node_addr = node_q;
		if (state_q == ST_NODE && cmd_q == CMD_LOAD_NODE) wr_node_en = 1'b1;
		if (state_q == ST_DEC && {1'b0, uni_q} < level) begin
			wr_node_en = 1'b1;
			node_wdata = node_rd_q;
			node_wdata.strategy = prop_q;
		end
		if (state_q == ST_WALK) node_addr = nbr_q;
		if (state_q == ST_NBR) node_addr = adj_rd_q;
		if (state_q == ST_ADD && mul_wait_q) node_addr = adj_rd_q;
		if (state_q == ST_CNT) node_addr = scan_q[NODE_W-1:0];
		adj_raddr = ADJ_W'(rec_q.adj_start + ADJ_W'(k_q)
			+ ADJ_W'(state_q == ST_ADD && !mul_wait_q));
	end

	always_ff @(posedge clk) begin
		if (wr_node_en) node_mem[node_q] <= node_wdata;
		node_rd_q <= node_mem[node_addr];
		if (state_q == ST_NODE && cmd_q == CMD_LOAD_ADJ) adj_mem[rec_q.adj_start] <= nbr_q;
		adj_rd_q <= adj_mem[adj_raddr];
	end

	pgu_sigmoid u_sig (.clk(clk), .du(du_q), .inv_temp(inv_temp_q), .level(level));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			mul_wait_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q <= cmd;
						node_q <= node;
						step_q <= prop_step;
						uni_q <= uniform;
						rec_q.strategy <= (strategy == 2'd3) ? 2'd0 : strategy;
						rec_q.locked <= zealot_flag;
						rec_q.adj_start <= (cmd == CMD_LOAD_ADJ) ? adj_addr : adj_start;
						rec_q.degree <= degree;
						nbr_q <= (cmd == CMD_LOAD_ADJ) ? neighbour : node;
						accepted <= 1'b0;
						new_strategy <= 2'd0;
						count_rock <= 13'd0;
						count_paper <= 13'd0;
						count_scissors <= 13'd0;
						free_converted <= 13'd0;
						c0_q <= 13'd0;
						c1_q <= 13'd0;
						c2_q <= 13'd0;
						cv_q <= 13'd0;
						scan_q <= '0;
						lim_q <= (node_count_q > 13'(MAX_NODES)) ? CNT_W'(MAX_NODES)
							: CNT_W'(node_count_q);
						state_q <= (cmd == CMD_COUNT) ? ST_CNT
							: (cmd == CMD_UPDATE) ? ST_WALK : ST_NODE;
					end
				end
				ST_NODE: state_q <= ST_OUT;
				ST_WALK: begin
					// Node record is being read; latch it next.
					state_q <= ST_NBR;
					k_q <= '0;
					du_q <= '0;
					mul_wait_q <= 1'b0;
				end
				ST_NBR: begin
					if (!mul_wait_q) begin
						rec_q.adj_start <= node_rd_q.adj_start;
						rec_q.locked <= node_rd_q.locked;
						cur_q <= node_rd_q.strategy;
						prop_q <= (step_q == 2'd1) ? ((node_rd_q.strategy == 2'd2) ? 2'd0
							: node_rd_q.strategy + 2'd1)
							: (step_q == 2'd2) ? ((node_rd_q.strategy == 2'd0) ? 2'd2
							: node_rd_q.strategy - 2'd1) : node_rd_q.strategy;
						deg_q <= (node_rd_q.degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE)
							: node_rd_q.degree;
						new_strategy <= node_rd_q.strategy;
						mul_wait_q <= 1'b1;
						if (node_rd_q.locked || node_rd_q.degree == '0 || step_q == 2'd0
							|| step_q == 2'd3)
							state_q <= ST_OUT;
					end else begin
						// The adjacency word for k_q is read here and lands in adj_rd_q for ST_ADD.
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					// adj_rd_q holds neighbour k; node_rd_q gets its strategy next.
					if (mul_wait_q) begin
						mul_wait_q <= 1'b0;
					end else begin
						du_q <= du_q + DU_W'(payoff(prop_q, node_rd_q.strategy, epsilon_q))
							- DU_W'(payoff(cur_q, node_rd_q.strategy, epsilon_q));
						k_q <= k_q + 1'b1;
						mul_wait_q <= 1'b1;
						if (k_q + 1'b1 == deg_q) state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_DEC;
				ST_DEC: begin
					if ({1'b0, uni_q} < level) begin
						accepted <= 1'b1;
						new_strategy <= prop_q;
					end
					state_q <= ST_OUT;
				end
				ST_CNT: begin
					if (scan_q != '0 && scan_q <= lim_q) begin
						case (node_rd_q.strategy)
							2'd0: c0_q <= c0_q + 1'b1;
							2'd1: c1_q <= c1_q + 1'b1;
							2'd2: c2_q <= c2_q + 1'b1;
							default: ;
						endcase
						if (!node_rd_q.locked && node_rd_q.strategy == zealot_q)
							cv_q <= cv_q + 1'b1;
					end
					if (scan_q == lim_q + 1'b1 || lim_q == '0) begin
						state_q <= ST_OUT;
					end
					scan_q <= scan_q + 1'b1;
				end
				ST_OUT: begin
					if (cmd_q == CMD_COUNT) begin
						count_rock <= c0_q;
						count_paper <= c1_q;
						count_scissors <= c2_q;
						free_converted <= cv_q;
					end
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ sv/pgu_checker.sv @@
// Port-level checker for the Potts graph update block, bound to the top.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module pgu_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic accepted,
	input wire logic [12:0] count_rock
);
	`AST_IMPL(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	`AST_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`AST_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(accepted))
	`AST_IMPL(a_field_excl, clk, arst_n, out_valid && accepted, count_rock == 13'd0)
endmodule
bind potts_glauber_graph_update pgu_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .accepted(accepted), .count_rock(count_rock));
`default_nettype wire

@@ verif/pgu_checker.sv @@
// Checker for the Potts Glauber graph update block: watches the item channels and the
// register port, predicts every result and checks it against the output. Depends on pgu_pkg.
`timescale 1ns / 1ps
module pgu_scoreboard
	import pgu_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic [1:0] cmd,
	input wire logic [11:0] node,
	input wire logic [1:0] strategy,
	input wire logic zealot_flag,
	input wire logic [15:0] adj_start,
	input wire logic [8:0] degree,
	input wire logic [15:0] adj_addr,
	input wire logic [11:0] neighbour,
	input wire logic [1:0] prop_step,
	input wire logic [15:0] uniform,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic accepted,
	input wire logic [1:0] new_strategy,
	input wire logic [12:0] count_rock,
	input wire logic [12:0] count_paper,
	input wire logic [12:0] count_scissors,
	input wire logic [12:0] free_converted,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_idx,
	input wire logic [15:0] cfg_data,
	output int fail_count,
	output int pending
);
	typedef struct packed {
		logic accepted;
		logic [1:0] new_strategy;
		logic [12:0] rock;
		logic [12:0] paper;
		logic [12:0] scissors;
		logic [12:0] converted;
	} spin_result_t;

	spin_result_t results_due[$];
	longint unsigned heat_bath_tab[0:256];

	logic [12:0] cfg_nodes;
	logic [14:0] cfg_eps;
	logic [15:0] cfg_beta;
	logic [1:0] cfg_zealot;

	logic [1:0] spin[0:MAX_NODES-1];
	logic locked[0:MAX_NODES-1];
	logic [15:0] first_edge[0:MAX_NODES-1];
	logic [8:0] node_deg[0:MAX_NODES-1];
	logic [11:0] edge_to[0:MAX_ADJ-1];

	initial begin
		longint unsigned p, d, s;
		p = 64'd1 << 32;
		for (int k = 0; k <= 128; k++) begin
			d = (64'd1 << 32) + p;
			s = ((64'd1 << 48) + d / 2) / d;
			heat_bath_tab[128 + k] = s;
			heat_bath_tab[128 - k] = 65536 - s;
			p = (p * 64'd4034748382 + (64'd1 << 31)) >> 32;
		end
		heat_bath_tab[128] = 32768;
	end

	function automatic longint gain(input logic [1:0] a, input logic [1:0] b);
		int diff;
		diff = (int'(b) + 3 - int'(a)) % 3;
		if (diff == 0) return ONE_Q14;
		if (diff == 1) return -longint'(cfg_eps);
		return longint'(cfg_eps);
	endfunction

	function automatic longint unsigned accept_level(input longint x);
		longint idx;
		idx = (x + 131072) >>> 18;
		if (idx > 128) idx = 128;
		if (idx < -128) idx = -128;
		return heat_bath_tab[idx + 128];
	endfunction

	function automatic spin_result_t attempt_flip();
		spin_result_t r;
		logic [1:0] cur, prop;
		int step, deg;
		longint du;
		logic [15:0] a;
		r = '0;
		cur = spin[node];
		step = int'(prop_step) % 3;
		deg = node_deg[node] > MAX_DEGREE ? MAX_DEGREE : int'(node_deg[node]);
		if (!locked[node] && deg != 0 && step != 0) begin
			prop = 2'((int'(cur) + step) % 3);
			du = 0;
			for (int k = 0; k < deg; k++) begin
				a = 16'(first_edge[node] + k);
				du += gain(prop, spin[edge_to[a]]) - gain(cur, spin[edge_to[a]]);
			end
			if (longint'(uniform) < accept_level(du * longint'(cfg_beta))) begin
				spin[node] = prop;
				cur = prop;
				r.accepted = 1'b1;
			end
		end
		r.new_strategy = cur;
		return r;
	endfunction

	function automatic spin_result_t tally();
		spin_result_t r;
		int lim;
		r = '0;
		lim = cfg_nodes > MAX_NODES ? MAX_NODES : int'(cfg_nodes);
		for (int i = 0; i < lim; i++) begin
			case (spin[i])
				2'd0: r.rock++;
				2'd1: r.paper++;
				2'd2: r.scissors++;
				default: ;
			endcase
			if (!locked[i] && spin[i] == cfg_zealot) r.converted++;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		spin_result_t got, want;
		if (!arst_n) begin
			cfg_nodes = 13'd1;
			cfg_eps = 15'd8192;
			cfg_beta = 16'd394;
			cfg_zealot = 2'd0;
			results_due.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
					REG_NODE_COUNT: cfg_nodes = cfg_data[12:0];
					REG_EPSILON: cfg_eps = cfg_data[14:0];
					REG_INV_TEMP: cfg_beta = cfg_data;
					REG_ZEALOT: cfg_zealot = cfg_data[1:0];
				endcase
			end
			if (out_valid && out_ready) begin
				got = {accepted, new_strategy, count_rock, count_paper, count_scissors,
					free_converted};
				if (results_due.size() == 0) begin
					$display("%0t: result with none expected: %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = results_due.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected acc %0b strat %0d cnt %0d %0d %0d conv %0d",
							$time, want.accepted, want.new_strategy, want.rock,
							want.paper, want.scissors, want.converted);
						$display("%0t:          actual   acc %0b strat %0d cnt %0d %0d %0d conv %0d",
							$time, got.accepted, got.new_strategy, got.rock,
							got.paper, got.scissors, got.converted);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				case (cmd_t'(cmd))
					CMD_LOAD_NODE: begin
						spin[node] = strategy == 2'd3 ? 2'd0 : strategy;
						locked[node] = zealot_flag;
						first_edge[node] = adj_start;
						node_deg[node] = degree;
						results_due.insert(results_due.size(), '0);
					end
					CMD_LOAD_ADJ: begin
						edge_to[adj_addr] = neighbour;
						results_due.insert(results_due.size(), '0);
					end
					CMD_UPDATE: results_due.insert(results_due.size(), attempt_flip());
					default: results_due.insert(results_due.size(), tally());
				endcase
			end
			pending <= results_due.size();
		end
	end
endmodule

@@ verif/tb_potts_glauber_graph_update.sv @@
// Testbench top for the Potts Glauber graph update block: builds a graph over the first
// nodes, then runs directed and random items over several register settings. Depends on
// pgu_pkg, pgu_scoreboard and the block itself.
`timescale 1ns / 1ps
module tb_potts_glauber_graph_update;
	import pgu_pkg::*;

	localparam int LOADED = 192;

	typedef struct {
		cmd_t cmd;
		logic [11:0] node;
		logic [1:0] strategy;
		logic zealot_flag;
		logic [15:0] adj_start;
		logic [8:0] degree;
		logic [15:0] adj_addr;
		logic [11:0] neighbour;
		logic [1:0] prop_step;
		logic [15:0] uniform;
	} graph_op_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = '0;
	logic [11:0] node = '0;
	logic [1:0] strategy = '0;
	logic zealot_flag = 1'b0;
	logic [15:0] adj_start = '0;
	logic [8:0] degree = '0;
	logic [15:0] adj_addr = '0;
	logic [11:0] neighbour = '0;
	logic [1:0] prop_step = '0;
	logic [15:0] uniform = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic accepted;
	logic [1:0] new_strategy;
	logic [12:0] count_rock, count_paper, count_scissors, free_converted;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = '0;
	logic [15:0] cfg_data = '0;
	int fail_count, pending;

	bit edge_written[0:MAX_ADJ-1];
	bit calm = 1'b0;
	int stall_left = 0;
	int n_items = 0, n_updates = 0, n_counts = 0;

	always #2 clk = ~clk;

	potts_glauber_graph_update u_dut (.*);
	pgu_scoreboard u_chk (.*);

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < 25) begin
			stall_left <= $urandom_range(0, 99) < 90 ? $urandom_range(0, 3)
				: $urandom_range(10, 40);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic int send_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [11:0] pick_node();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return 12'($urandom_range(0, 63));
		if (r < 95) return 12'($urandom_range(0, LOADED - 1));
		return 12'd4095;
	endfunction

	function automatic graph_op_t noise_op(input cmd_t c);
		graph_op_t op;
		op.cmd = c;
		op.node = 12'($urandom);
		op.strategy = 2'($urandom);
		op.zealot_flag = 1'($urandom);
		op.adj_start = 16'($urandom);
		op.degree = 9'($urandom);
		op.adj_addr = 16'($urandom);
		op.neighbour = 12'($urandom);
		op.prop_step = 2'($urandom_range(1, 2));
		op.uniform = 16'($urandom);
		return op;
	endfunction

	function automatic bit span_written(input logic [15:0] s, input int d);
		int walk;
		walk = d > MAX_DEGREE ? MAX_DEGREE : d;
		for (int k = 0; k < walk; k++)
			if (!edge_written[16'(s + k)]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic graph_op_t node_op(input logic [11:0] n);
		graph_op_t op;
		int r, d;
		op = noise_op(CMD_LOAD_NODE);
		op.node = n;
		op.strategy = $urandom_range(0, 99) < 5 ? 2'd3 : 2'($urandom_range(0, 2));
		op.zealot_flag = $urandom_range(0, 99) < 20;
		do begin
			r = $urandom_range(0, 99);
			if (r < 70) d = $urandom_range(1, 16);
			else if (r < 80) d = 0;
			else if (r < 88) d = $urandom_range(17, 64);
			else if (r < 94) d = $urandom_range(256, 511);
			else d = $urandom_range(1, 12);
			if (r >= 94) op.adj_start = 16'($urandom_range(65528, 65535));
			else if (r < 4) op.adj_start = 16'($urandom);
			else op.adj_start = 16'($urandom_range(0, 288 - (d > 256 ? 256 : d)));
		end while (!span_written(op.adj_start, d));
		op.degree = 9'(d);
		return op;
	endfunction

	function automatic graph_op_t flip_op(input logic [11:0] n);
		graph_op_t op;
		int r;
		op = noise_op(CMD_UPDATE);
		op.node = n;
		r = $urandom_range(0, 99);
		if (r < 4) op.prop_step = 2'd0;
		else if (r < 8) op.prop_step = 2'd3;
		return op;
	endfunction

	task automatic send(input graph_op_t op);
		int gap;
		gap = send_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op.cmd;
		node <= op.node;
		strategy <= op.strategy;
		zealot_flag <= op.zealot_flag;
		adj_start <= op.adj_start;
		degree <= op.degree;
		adj_addr <= op.adj_addr;
		neighbour <= op.neighbour;
		prop_step <= op.prop_step;
		uniform <= op.uniform;
		if (op.cmd == CMD_LOAD_ADJ) edge_written[op.adj_addr] = 1'b1;
		n_items++;
		if (op.cmd == CMD_UPDATE) n_updates++;
		if (op.cmd == CMD_COUNT) n_counts++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(input logic [15:0] nc, input logic [15:0] eps,
			input logic [15:0] beta, input logic [15:0] zs);
		drain();
		write_reg(REG_NODE_COUNT, nc);
		write_reg(REG_EPSILON, eps);
		write_reg(REG_INV_TEMP, beta);
		write_reg(REG_ZEALOT, zs);
	endtask

	task automatic edge_op(input logic [15:0] a);
		graph_op_t op;
		op = noise_op(CMD_LOAD_ADJ);
		op.adj_addr = a;
		op.neighbour = pick_node();
		send(op);
	endtask

	initial begin
		graph_op_t op;
		int r;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int a = 0; a < 288; a++) edge_op(16'(a));
		for (int a = 65528; a < 65536; a++) edge_op(16'(a));
		for (int n = 0; n < LOADED; n++) send(node_op(12'(n)));

		op = node_op(12'd0);
		op.zealot_flag = 1'b0; op.adj_start = 16'd0; op.degree = 9'd511;
		send(op);
		op = node_op(12'd1);
		op.zealot_flag = 1'b0; op.adj_start = 16'd65530; op.degree = 9'd12;
		send(op);
		op = node_op(12'd2);
		op.zealot_flag = 1'b1; op.adj_start = 16'd8; op.degree = 9'd5;
		send(op);
		op = node_op(12'd3);
		op.zealot_flag = 1'b0; op.degree = 9'd0;
		send(op);
		op = node_op(12'd4095);
		op.strategy = 2'd3; op.zealot_flag = 1'b0; op.adj_start = 16'd32; op.degree = 9'd256;
		send(op);
		op = noise_op(CMD_LOAD_ADJ);
		op.adj_addr = 16'hFFFF; op.neighbour = 12'hFFF;
		send(op);
		for (int n = 0; n < 4; n++) begin
			op = flip_op(12'(n)); op.uniform = 16'd0; op.prop_step = 2'd1; send(op);
			op = flip_op(12'(n)); op.uniform = 16'hFFFF; op.prop_step = 2'd2; send(op);
		end
		op = flip_op(12'd4095); op.prop_step = 2'd0; send(op);
		op = flip_op(12'd4095); op.prop_step = 2'd3; send(op);
		op = flip_op(12'd4095); op.uniform = 16'd0; send(op);
		send(noise_op(CMD_COUNT));

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_regs(16'd32, 16'd8192, 16'd394, 16'd0);
				1: set_regs(16'd0, 16'd0, 16'd1, 16'd3);
				2: set_regs(16'(LOADED), 16'd32767, 16'd65535, 16'd2);
				3: set_regs(16'(LOADED - 1), 16'($urandom_range(0, 32767)), 16'd0, 16'd1);
				default: set_regs(16'($urandom_range(1, 64)), 16'($urandom_range(0, 32767)),
					16'($urandom_range(1, 2000)), 16'($urandom_range(0, 3)));
			endcase
			calm = (phase == 4);
			for (int i = 0; i < 125; i++) begin
				if (i == 60) drain();
				r = $urandom_range(0, 99);
				if (r < 55) begin
					send(flip_op(pick_node()));
				end else if (r < 70) begin
					send(node_op($urandom_range(0, 99) < 80 ? 12'($urandom_range(0, 63))
						: 12'($urandom)));
				end else if (r < 92) begin
					edge_op($urandom_range(0, 99) < 70 ? 16'($urandom_range(0, 287))
						: 16'($urandom));
				end else if (r < 96 || phase < 2 || phase > 3) begin
					send(noise_op(CMD_COUNT));
				end else begin
					send(flip_op(pick_node()));
				end
			end
		end
		calm = 1'b0;

		drain();
		repeat (50) @(posedge clk);
		$display("Covered %0d items: %0d update attempts and %0d counts over six settings,",
			n_items, n_updates, n_counts);
		$display("with wrapped and oversized neighbour lists, locked nodes and random stalls.");
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+sv
sv/pgu_pkg.sv
sv/pgu_sigmoid.sv
sv/potts_glauber_graph_update.sv
sv/pgu_checker.sv
verif/pgu_checker.sv
verif/tb_potts_glauber_graph_update.sv
